// ===== design/lphm_pkg.sv =====
package lphm_pkg;

   localparam int unsigned CapacityDefault = 1024;
   localparam int unsigned LoadDivisor = 2;
   localparam int unsigned CountWidth = 10;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

endpackage

// ===== design/linear_probe_hash_map.sv =====
// Open-addressing key/value table with linear probing.
// Input channel req_*: operation, key, precomputed key_hash and value, with
// req_valid/req_ready. Result channel rsp_*: status, hit, value_out, key_out
// and entry_count, with rsp_valid/rsp_ready. Every request gives one result.
// The table lives in one synchronous memory holding used flag, key, hash and
// value per slot. A request walks its probe chain one slot at a time, each
// slot in a read-issue step and then a compare step. Insert and lookup end
// there; remove continues with a backward-shift pass over the following
// cluster, with the same read-issue and compare steps per slot examined. A
// moved entry is written back in its compare step, so moves add no time.
// After reset a clearing pass writes every slot unused, one slot per cycle;
// no request is taken during the pass.
// The result stays in an output register until it is transferred; the block
// takes no new request while a result waits, so a stalled receiver simply
// holds the block.
module linear_probe_hash_map
   import lphm_pkg::*;
#(
   parameter int unsigned CAPACITY = CapacityDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [31:0]           req_key,
   input  logic [31:0]           req_key_hash,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_hit,
   output logic [31:0]           rsp_value_out,
   output logic [31:0]           rsp_key_out,
   output logic [CountWidth-1:0] rsp_entry_count
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = AW + 1;
   localparam logic [CW-1:0] LoadLimit = CW'(CAPACITY / LoadDivisor);

   typedef struct packed {
      logic        used;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] value;
   } slot_type;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_PREAD = 7'b0000100,
      S_PCMP  = 7'b0001000,
      S_DREAD = 7'b0010000,
      S_DCMP  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   slot_type mem [CAPACITY];
   slot_type rd_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   slot_type        wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in, hole_ff, hole_in;
   logic [CW-1:0] n_ff, n_in, cnt_ff, cnt_in;
   op_type        op_ff, op_in;
   logic [31:0]   key_ff, key_in, hash_ff, hash_in, val_ff, val_in;
   logic [1:0]    st_ff, st_in;
   logic          hit_ff, hit_in;
   logic [31:0]   vout_ff, vout_in, kout_ff, kout_in;

   logic [AW-1:0] home, dist_home, dist_hole, nxt;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_hit = hit_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_key_out = kout_ff;
   assign rsp_entry_count = CountWidth'(cnt_ff);

   assign nxt = idx_ff + AW'(1);
   assign home = rd_ff.hash[AW-1:0];
   assign dist_home = idx_ff - home;
   assign dist_hole = idx_ff - hole_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hole_in = hole_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      key_in = key_ff;
      hash_in = hash_ff;
      val_in = val_ff;
      st_in = st_ff;
      hit_in = hit_ff;
      vout_in = vout_ff;
      kout_in = kout_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
            idx_in = nxt;
            if (idx_ff == AW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = op_type'(req_operation);
               key_in = req_key;
               hash_in = req_key_hash;
               val_in = req_value;
               idx_in = req_key_hash[AW-1:0];
               n_in = '0;
               st_in = ST_MISS;
               hit_in = 1'b0;
               vout_in = '0;
               kout_in = '0;
               state_in = (op_type'(req_operation) == OP_UNUSED) ? S_RESP : S_PREAD;
            end
         end
         S_PREAD: begin
            state_in = S_PCMP;
         end
         S_PCMP: begin
            if (!rd_ff.used) begin
               // Empty slot ends the chain: a new key goes here on insert, unless the table is at its load limit.
               if (op_ff == OP_INSERT) begin
                  if (cnt_ff >= LoadLimit) begin
                     st_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = '{used: 1'b1, key: key_ff, hash: hash_ff, value: val_ff};
                     cnt_in = cnt_ff + CW'(1);
                     st_in = ST_OK;
                  end
               end
               state_in = S_RESP;
            end else if (rd_ff.hash == hash_ff && rd_ff.key == key_ff) begin
               st_in = ST_OK;
               hit_in = 1'b1;
               vout_in = rd_ff.value;
               kout_in = rd_ff.key;
               if (op_ff == OP_INSERT) begin
                  wr_en = 1'b1;
                  wr_data.value = val_ff;
                  state_in = S_RESP;
               end else if (op_ff == OP_REMOVE) begin
                  hole_in = idx_ff;
                  idx_in = nxt;
                  n_in = '0;
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - CW'(1);
                  end
                  state_in = S_DREAD;
               end else begin
                  state_in = S_RESP;
               end
            end else if (n_ff == CW'(CAPACITY - 1)) begin
               // Whole table visited without a free slot.
               if (op_ff == OP_INSERT) begin
                  st_in = ST_FULL;
               end
               state_in = S_RESP;
            end else begin
               idx_in = nxt;
               n_in = n_ff + CW'(1);
               state_in = S_PREAD;
            end
         end
         S_DREAD: begin
            state_in = S_DCMP;
         end
         S_DCMP: begin
            if (!rd_ff.used || n_ff == CW'(CAPACITY - 1)) begin
               wr_en = 1'b1;
               wr_addr = hole_ff;
               wr_data = '0;
               state_in = S_RESP;
            end else begin
               // Move the entry back unless its home lies cyclically in (hole, idx].
               if (dist_home >= dist_hole) begin
                  wr_en = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = rd_ff;
                  hole_in = idx_ff;
               end
               idx_in = nxt;
               n_in = n_ff + CW'(1);
               state_in = S_DREAD;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
      hole_ff <= hole_in;
      n_ff <= n_in;
      op_ff <= op_in;
      key_ff <= key_in;
      hash_ff <= hash_in;
      val_ff <= val_in;
      st_ff <= st_in;
      hit_ff <= hit_in;
      vout_ff <= vout_in;
      kout_ff <= kout_in;
   end

endmodule
